[src/wsa_pkg.sv]
// Shared types, constants and helper functions of the weighted spectrum accumulator.
package wsa_pkg;

	localparam int NUM_CHANNELS = 1024;
	localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CFG_DW       = 31;
	localparam int CNT_W        = 6;
	localparam int CORDIC_STEPS = 17;
	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = 64;

	localparam logic signed [19:0] PI_Q16     = 20'sd205887;
	localparam logic [47:0]        WEIGHT_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0]        SQRT_BIT0  = 64'h4000_0000_0000_0000;

	typedef enum logic [2:0] {
		CFG_VECTOR_MODE  = 3'd0,
		CFG_UV_MIN       = 3'd1,
		CFG_UV_MAX       = 3'd2,
		CFG_FIRST_RECORD = 3'd3,
		CFG_LAST_RECORD  = 3'd4,
		CFG_WEIGHT_SCALE = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_UU, MUL_VV, MUL_LO, MUL_HI, MUL_RR, MUL_II,
		MUL_WRE, MUL_WIM, MUL_WAMP, MUL_WPH, MUL_WLO, MUL_WHI
	} mul_sel_t;

	typedef struct packed {
		logic        kind;
		logic [9:0]  channel;
		logic [19:0] record_index;
		logic signed [31:0] u_coord;
		logic signed [31:0] v_coord;
		logic signed [31:0] sample_re;
		logic signed [31:0] sample_im;
		logic signed [23:0] sample_weight;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] mean_re;
		logic signed [31:0] mean_im;
		logic [47:0]        total_weight;
	} out_item_t;

	typedef struct packed {
		logic        vector_mode;
		logic [30:0] uv_min;
		logic [30:0] uv_max;
		logic [19:0] first_record;
		logic [19:0] last_record;
		logic [23:0] weight_scale;
	} cfg_t;

	typedef struct packed {
		logic             load_item;
		logic             mem_rd;
		logic             mem_wr;
		logic             wr_zero;
		logic             clr;
		logic [CH_AW-1:0] clr_addr;
		mul_sel_t         mul_sel;
		logic             r2_set;
		logic             r2_add;
		logic             lo_set;
		logic             sq_set;
		logic             it_init;
		logic             it_step;
		logic             acc_re;
		logic             acc_im;
		logic             div_init;
		logic             div_step;
		logic             tlo_set;
		logic             out_load;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic ch_ok;
		logic pass;
	} sts_t;

	// round(atan(2^-i) * 65536)
	function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
		logic signed [19:0] r;
		case (i)
			5'd0:  r = 20'sd51472;
			5'd1:  r = 20'sd30385;
			5'd2:  r = 20'sd16055;
			5'd3:  r = 20'sd8150;
			5'd4:  r = 20'sd4091;
			5'd5:  r = 20'sd2047;
			5'd6:  r = 20'sd1024;
			5'd7:  r = 20'sd512;
			5'd8:  r = 20'sd256;
			5'd9:  r = 20'sd128;
			5'd10: r = 20'sd64;
			5'd11: r = 20'sd32;
			5'd12: r = 20'sd16;
			5'd13: r = 20'sd8;
			5'd14: r = 20'sd4;
			5'd15: r = 20'sd2;
			5'd16: r = 20'sd1;
			default: r = 20'sd0;
		endcase
		return r;
	endfunction

endpackage

[src/wsa_ctrl.sv]
// Sequencing state machine of the weighted spectrum accumulator.
module wsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          vector_mode,
	input  wsa_pkg::sts_t sts,
	output wsa_pkg::cmd_t cmd
);

	typedef enum logic [19:0] {
		ST_CLEAR  = 20'h00001,
		ST_IDLE   = 20'h00002,
		ST_FETCH  = 20'h00004,
		ST_A_UU   = 20'h00008,
		ST_A_VV   = 20'h00010,
		ST_A_LO   = 20'h00020,
		ST_A_HI   = 20'h00040,
		ST_A_CHK  = 20'h00080,
		ST_S_RR   = 20'h00100,
		ST_S_II   = 20'h00200,
		ST_S_SQ   = 20'h00400,
		ST_S_ITER = 20'h00800,
		ST_M_RE   = 20'h01000,
		ST_M_IM   = 20'h02000,
		ST_ACC_IM = 20'h04000,
		ST_WB     = 20'h08000,
		ST_R_TLO  = 20'h10000,
		ST_R_THI  = 20'h20000,
		ST_R_DIV  = 20'h40000,
		ST_R_OUT  = 20'h80000
	} state_t;

	state_t                       st_q, st_n;
	logic [wsa_pkg::CNT_W-1:0]    cnt_q;
	logic [wsa_pkg::CH_AW-1:0]    clr_q;
	logic                         out_valid_q;

	always_comb begin
		st_n         = st_q;
		cmd          = '0;
		cmd.mul_sel  = wsa_pkg::MUL_NONE;
		cmd.cnt      = cnt_q;
		cmd.clr_addr = clr_q;
		in_ready     = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				cmd.mem_wr  = 1'b1;
				cmd.wr_zero = 1'b1;
				cmd.clr     = 1'b1;
				if (clr_q == wsa_pkg::CH_AW'(wsa_pkg::NUM_CHANNELS - 1))
					st_n = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
				if (in_valid)
					st_n = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.mem_rd = 1'b1;
				st_n = sts.kind ? ST_R_TLO : ST_A_UU;
			end
			ST_A_UU: begin
				cmd.mul_sel = wsa_pkg::MUL_UU;
				st_n = ST_A_VV;
			end
			ST_A_VV: begin
				cmd.mul_sel = wsa_pkg::MUL_VV;
				cmd.r2_set  = 1'b1;
				st_n = ST_A_LO;
			end
			ST_A_LO: begin
				cmd.mul_sel = wsa_pkg::MUL_LO;
				cmd.r2_add  = 1'b1;
				st_n = ST_A_HI;
			end
			ST_A_HI: begin
				cmd.mul_sel = wsa_pkg::MUL_HI;
				cmd.lo_set  = 1'b1;
				st_n = ST_A_CHK;
			end
			ST_A_CHK: begin
				if (!sts.pass)
					st_n = ST_IDLE;
				else if (vector_mode)
					st_n = ST_M_RE;
				else
					st_n = ST_S_RR;
			end
			ST_S_RR: begin
				cmd.mul_sel = wsa_pkg::MUL_RR;
				st_n = ST_S_II;
			end
			ST_S_II: begin
				cmd.mul_sel = wsa_pkg::MUL_II;
				cmd.sq_set  = 1'b1;
				st_n = ST_S_SQ;
			end
			ST_S_SQ: begin
				cmd.it_init = 1'b1;
				st_n = ST_S_ITER;
			end
			ST_S_ITER: begin
				cmd.it_step = 1'b1;
				if (cnt_q == wsa_pkg::CNT_W'(wsa_pkg::SQRT_STEPS - 1))
					st_n = ST_M_RE;
			end
			ST_M_RE: begin
				cmd.mul_sel = vector_mode ? wsa_pkg::MUL_WRE : wsa_pkg::MUL_WAMP;
				st_n = ST_M_IM;
			end
			ST_M_IM: begin
				cmd.mul_sel = vector_mode ? wsa_pkg::MUL_WIM : wsa_pkg::MUL_WPH;
				cmd.acc_re  = 1'b1;
				st_n = ST_ACC_IM;
			end
			ST_ACC_IM: begin
				cmd.acc_im = 1'b1;
				st_n = ST_WB;
			end
			ST_WB: begin
				cmd.mem_wr = 1'b1;
				st_n = ST_IDLE;
			end
			ST_R_TLO: begin
				cmd.mul_sel  = wsa_pkg::MUL_WLO;
				cmd.div_init = 1'b1;
				st_n = ST_R_THI;
			end
			ST_R_THI: begin
				cmd.mul_sel = wsa_pkg::MUL_WHI;
				cmd.tlo_set = 1'b1;
				st_n = ST_R_DIV;
			end
			ST_R_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == wsa_pkg::CNT_W'(wsa_pkg::DIV_STEPS - 1))
					st_n = ST_R_OUT;
			end
			ST_R_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.wr_zero  = 1'b1;
					cmd.mem_wr   = sts.ch_ok;
					st_n = ST_IDLE;
				end
			end
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (st_q == ST_S_ITER || st_q == ST_R_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (st_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/wsa_datapath.sv]
// Channel sum memory, shared multiplier, square root, CORDIC and divider datapath.
module wsa_datapath (
	input  logic                clk,
	input  wsa_pkg::in_item_t   in_data,
	input  wsa_pkg::cfg_t       cfg,
	input  wsa_pkg::cmd_t       cmd,
	output wsa_pkg::sts_t       sts,
	output wsa_pkg::out_item_t  out_data
);

	logic signed [63:0] mem_re [wsa_pkg::NUM_CHANNELS];
	logic signed [63:0] mem_im [wsa_pkg::NUM_CHANNELS];
	logic [47:0]        mem_w  [wsa_pkg::NUM_CHANNELS];

	wsa_pkg::in_item_t  item_q;
	wsa_pkg::out_item_t out_q;
	logic signed [63:0] re_q, im_q, prod_q;
	logic [47:0]        w_q, tlo_q;
	logic [63:0]        r2_q, lo2_q, sq_q;
	logic [63:0]        sn_q, rt_q, sb_q;
	logic signed [59:0] cx_q, cy_q;
	logic signed [19:0] cz_q;
	logic [63:0]        dre_q, dim_q;
	logic [47:0]        rre_q, rim_q;
	logic               nre_q, nim_q;

	logic [wsa_pkg::CH_AW-1:0] ch_idx, wr_addr;
	logic               ch_ok, w_pos, rec_ok, uv_ok;
	logic signed [32:0] mul_a, mul_b, w_ext;
	logic signed [65:0] mul_full;
	logic [48:0]        w_sum;
	logic [63:0]        rt_t, n0;
	logic signed [59:0] x0, y0, xs, ys;
	logic [4:0]         sh;
	logic [71:0]        tw_full;
	logic [47:0]        tw;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic logic [111:0] div_bit(input logic [47:0] rem, input logic [63:0] dq,
		input logic [47:0] d);
		logic [48:0] t;
		logic        ge;
		t  = {rem, dq[63]};
		ge = t >= {1'b0, d};
		return {ge ? 48'(t - {1'b0, d}) : t[47:0], dq[62:0], ge};
	endfunction

	function automatic logic [31:0] mean_sat(input logic [63:0] q, input logic neg);
		if (neg)
			return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
		return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	assign ch_idx  = wsa_pkg::CH_AW'(item_q.channel);
	assign ch_ok   = 32'(item_q.channel) < 32'(wsa_pkg::NUM_CHANNELS);
	assign wr_addr = cmd.clr ? cmd.clr_addr : ch_idx;
	assign w_ext   = {{9{item_q.sample_weight[23]}}, item_q.sample_weight};

	assign w_pos  = !item_q.sample_weight[23] && (item_q.sample_weight != '0);
	assign rec_ok = (item_q.record_index >= cfg.first_record) &&
		(item_q.record_index <= cfg.last_record);
	assign uv_ok  = (cfg.uv_max == '0) || ((r2_q >= lo2_q) && (r2_q <= $unsigned(prod_q)));

	assign sts.kind  = item_q.kind;
	assign sts.ch_ok = ch_ok;
	assign sts.pass  = ch_ok && w_pos && rec_ok && uv_ok;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			wsa_pkg::MUL_UU: begin
				mul_a = {item_q.u_coord[31], item_q.u_coord};
				mul_b = mul_a;
			end
			wsa_pkg::MUL_VV: begin
				mul_a = {item_q.v_coord[31], item_q.v_coord};
				mul_b = mul_a;
			end
			wsa_pkg::MUL_LO: begin
				mul_a = {2'b00, cfg.uv_min};
				mul_b = mul_a;
			end
			wsa_pkg::MUL_HI: begin
				mul_a = {2'b00, cfg.uv_max};
				mul_b = mul_a;
			end
			wsa_pkg::MUL_RR: begin
				mul_a = {item_q.sample_re[31], item_q.sample_re};
				mul_b = mul_a;
			end
			wsa_pkg::MUL_II: begin
				mul_a = {item_q.sample_im[31], item_q.sample_im};
				mul_b = mul_a;
			end
			wsa_pkg::MUL_WRE: begin
				mul_a = w_ext;
				mul_b = {item_q.sample_re[31], item_q.sample_re};
			end
			wsa_pkg::MUL_WIM: begin
				mul_a = w_ext;
				mul_b = {item_q.sample_im[31], item_q.sample_im};
			end
			wsa_pkg::MUL_WAMP: begin
				mul_a = w_ext;
				mul_b = {1'b0, rt_q[31:0]};
			end
			wsa_pkg::MUL_WPH: begin
				mul_a = w_ext;
				mul_b = {{13{cz_q[19]}}, cz_q};
			end
			wsa_pkg::MUL_WLO: begin
				mul_a = {9'd0, w_q[23:0]};
				mul_b = {9'd0, cfg.weight_scale};
			end
			wsa_pkg::MUL_WHI: begin
				mul_a = {9'd0, w_q[47:24]};
				mul_b = {9'd0, cfg.weight_scale};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	assign w_sum   = {1'b0, w_q} + {25'd0, item_q.sample_weight};
	assign n0      = sq_q + $unsigned(prod_q);
	assign rt_t    = rt_q + sb_q;
	assign sh      = cmd.cnt[4:0];
	assign xs      = cx_q >>> sh;
	assign ys      = cy_q >>> sh;
	assign x0      = {{4{item_q.sample_re[31]}}, item_q.sample_re, 24'd0};
	assign y0      = {{4{item_q.sample_im[31]}}, item_q.sample_im, 24'd0};
	assign tw_full = {prod_q[47:0], 24'd0} + {24'd0, tlo_q};
	assign tw      = (tw_full[71:64] != '0) ? wsa_pkg::WEIGHT_MAX : tw_full[63:16];

	// channel memory with registered read; read registers double as accumulators
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_re[wr_addr] <= cmd.wr_zero ? '0 : re_q;
			mem_im[wr_addr] <= cmd.wr_zero ? '0 : im_q;
			mem_w[wr_addr]  <= cmd.wr_zero ? '0 : w_q;
		end
		if (cmd.mem_rd) begin
			re_q <= mem_re[ch_idx];
			im_q <= mem_im[ch_idx];
			w_q  <= mem_w[ch_idx];
		end else begin
			if (cmd.acc_re)
				re_q <= sat_add(re_q, prod_q);
			if (cmd.acc_im) begin
				im_q <= sat_add(im_q, prod_q);
				w_q  <= w_sum[48] ? wsa_pkg::WEIGHT_MAX : w_sum[47:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= in_data;
		if (cmd.mul_sel != wsa_pkg::MUL_NONE)
			prod_q <= mul_full[63:0];
		if (cmd.r2_set)
			r2_q <= $unsigned(prod_q);
		if (cmd.r2_add)
			r2_q <= r2_q + $unsigned(prod_q);
		if (cmd.lo_set)
			lo2_q <= $unsigned(prod_q);
		if (cmd.sq_set)
			sq_q <= $unsigned(prod_q);
		if (cmd.tlo_set)
			tlo_q <= prod_q[47:0];
	end

	// square root and CORDIC phase, one step per cycle
	always_ff @(posedge clk) begin
		if (cmd.it_init) begin
			sn_q <= n0;
			rt_q <= '0;
			sb_q <= wsa_pkg::SQRT_BIT0;
			if (item_q.sample_re[31]) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= item_q.sample_im[31] ? -wsa_pkg::PI_Q16 : wsa_pkg::PI_Q16;
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (cmd.it_step) begin
			if (sn_q >= rt_t) begin
				sn_q <= sn_q - rt_t;
				rt_q <= (rt_q >> 1) + sb_q;
			end else begin
				rt_q <= rt_q >> 1;
			end
			sb_q <= sb_q >> 2;
			if (32'(cmd.cnt) < 32'(wsa_pkg::CORDIC_STEPS)) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + wsa_pkg::atan_q16(sh);
				end else if (cy_q < 0) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - wsa_pkg::atan_q16(sh);
				end
			end
		end
	end

	// restoring dividers for both means, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			nre_q <= re_q[63];
			nim_q <= im_q[63];
			dre_q <= re_q[63] ? ~$unsigned(re_q) + 64'd1 : $unsigned(re_q);
			dim_q <= im_q[63] ? ~$unsigned(im_q) + 64'd1 : $unsigned(im_q);
			rre_q <= '0;
			rim_q <= '0;
		end else if (cmd.div_step) begin
			{rre_q, dre_q} <= div_bit(rre_q, dre_q, w_q);
			{rim_q, dim_q} <= div_bit(rim_q, dim_q, w_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (!ch_ok || w_q == '0) begin
				out_q <= '0;
			end else begin
				out_q.mean_re      <= mean_sat(dre_q, nre_q);
				out_q.mean_im      <= mean_sat(dim_q, nim_q);
				out_q.total_weight <= tw;
			end
		end
	end

	assign out_data = out_q;

endmodule

[src/weighted_spectrum_accumulator.sv]
// Top level of the weighted spectrum accumulator: configuration registers and wiring.
// Works on one item at a time. After reset the block zeroes all 1024 channels, one per
// cycle, and takes no item until the last one is zeroed. A scalar accumulate runs a
// 32-step square root with a 17-step CORDIC alongside; a read runs the 64-step bit-serial
// divider and then waits, if need be, for the previous result to be taken. One shared
// 33x33 multiplier serves all products. Configuration writes are taken at any time but
// belong to idle periods.
module weighted_spectrum_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  wsa_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wsa_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [wsa_pkg::CFG_DW-1:0]      cfg_wdata
);

	wsa_pkg::cfg_t cfg_q;
	wsa_pkg::cmd_t cmd;
	wsa_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vector_mode  <= 1'b1;
			cfg_q.uv_min       <= '0;
			cfg_q.uv_max       <= '0;
			cfg_q.first_record <= '0;
			cfg_q.last_record  <= 20'hFFFFF;
			cfg_q.weight_scale <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				wsa_pkg::CFG_VECTOR_MODE:  cfg_q.vector_mode  <= cfg_wdata[0];
				wsa_pkg::CFG_UV_MIN:       cfg_q.uv_min       <= cfg_wdata[30:0];
				wsa_pkg::CFG_UV_MAX:       cfg_q.uv_max       <= cfg_wdata[30:0];
				wsa_pkg::CFG_FIRST_RECORD: cfg_q.first_record <= cfg_wdata[19:0];
				wsa_pkg::CFG_LAST_RECORD:  cfg_q.last_record  <= cfg_wdata[19:0];
				wsa_pkg::CFG_WEIGHT_SCALE: cfg_q.weight_scale <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	wsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.vector_mode(cfg_q.vector_mode),
		.sts        (sts),
		.cmd        (cmd)
	);

	wsa_datapath u_dp (
		.clk     (clk),
		.in_data (in_data),
		.cfg     (cfg_q),
		.cmd     (cmd),
		.sts     (sts),
		.out_data(out_data)
	);

`ifndef SYNTHESIS
	a_no_accept_during_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> !in_ready) else $error("transfer possible during memory write");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second transfer while busy");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid) else $error("loaded result not presented");
	a_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_im |=> cmd.mem_wr) else $error("accumulation not written back");
`endif

endmodule

[bench/tb_weighted_spectrum_accumulator.sv]
// Testbench of the weighted spectrum accumulator: random and directed transfers vs a predictor.
module tb_weighted_spectrum_accumulator;

	localparam logic [47:0] WMAX = 48'hFFFF_FFFF_FFFF;
	localparam longint PI_RAD = 205887;

	class spectrum_scoreboard;
		longint sum_re[wsa_pkg::NUM_CHANNELS];
		longint sum_im[wsa_pkg::NUM_CHANNELS];
		logic [47:0] sum_w[wsa_pkg::NUM_CHANNELS];
		wsa_pkg::cfg_t cfg;
		wsa_pkg::out_item_t pending[$];
		int errors;

		function void clear_all();
			foreach (sum_re[i]) begin
				sum_re[i] = 0;
				sum_im[i] = 0;
				sum_w[i] = 0;
			end
			cfg.vector_mode = 1'b1;
			cfg.uv_min = '0;
			cfg.uv_max = '0;
			cfg.first_record = '0;
			cfg.last_record = 20'hFFFFF;
			cfg.weight_scale = 24'd65536;
			errors = 0;
		endfunction

		function longint sat_sum(longint a, longint b);
			longint s;
			s = a + b;
			if (b > 0 && s < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
			if (b < 0 && s > a) return 64'sh8000_0000_0000_0000;
			return s;
		endfunction

		function longint shr_floor(longint v, int s);
			return v >>> s;
		endfunction

		function longint unsigned root_floor(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'h4000_0000_0000_0000;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function longint angle_q16(longint re, longint im);
			longint x, y, z, xs, ys;
			longint tab[17];
			tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256,
				128, 64, 32, 16, 8, 4, 2, 1};
			if (re == 0 && im == 0) return 0;
			x = re * 16777216;
			y = im * 16777216;
			z = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = (im >= 0) ? PI_RAD : -PI_RAD;
			end
			for (int i = 0; i < 17; i++) begin
				xs = shr_floor(x, i);
				ys = shr_floor(y, i);
				if (y > 0) begin
					x += ys; y -= xs; z += tab[i];
				end else if (y < 0) begin
					x -= ys; y += xs; z -= tab[i];
				end
			end
			return z;
		endfunction

		function logic [31:0] mean_q16(longint s, logic [47:0] w);
			longint unsigned mag, q;
			mag = (s < 0) ? longint'(-(s + 1)) + 1 : s;
			q = mag / {16'd0, w};
			if (s < 0) begin
				if (q > 64'h8000_0000) q = 64'h8000_0000;
				return 32'(-q);
			end
			if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
			return q[31:0];
		endfunction

		function void note_input(wsa_pkg::in_item_t it);
			wsa_pkg::out_item_t r;
			longint u, v, re, im, w;
			longint unsigned r2, lo2, hi2, amp, nw, tw;
			int ch;
			ch = it.channel;
			if (it.kind) begin
				r = '0;
				if (sum_w[ch] != 0) begin
					r.mean_re = mean_q16(sum_re[ch], sum_w[ch]);
					r.mean_im = mean_q16(sum_im[ch], sum_w[ch]);
					if (cfg.weight_scale != 0 &&
						{16'd0, sum_w[ch]} > 64'hFFFF_FFFF_FFFF_FFFF / cfg.weight_scale)
						tw = WMAX;
					else
						tw = ({16'd0, sum_w[ch]} * cfg.weight_scale) >> 16;
					r.total_weight = (tw > WMAX) ? WMAX : tw[47:0];
				end
				sum_re[ch] = 0; sum_im[ch] = 0; sum_w[ch] = 0;
				pending.push_back(r);
				return;
			end
			u = it.u_coord; v = it.v_coord;
			re = it.sample_re; im = it.sample_im; w = it.sample_weight;
			if (w <= 0) return;
			if (it.record_index < cfg.first_record || it.record_index > cfg.last_record) return;
			r2 = longint'(u * u) + longint'(v * v);
			lo2 = longint'(cfg.uv_min) * cfg.uv_min;
			hi2 = longint'(cfg.uv_max) * cfg.uv_max;
			if (cfg.uv_max != 0 && (r2 < lo2 || r2 > hi2)) return;
			if (cfg.vector_mode) begin
				sum_re[ch] = sat_sum(sum_re[ch], w * re);
				sum_im[ch] = sat_sum(sum_im[ch], w * im);
			end else begin
				amp = root_floor(longint'(re * re) + longint'(im * im));
				sum_re[ch] = sat_sum(sum_re[ch], w * longint'(amp));
				sum_im[ch] = sat_sum(sum_im[ch], w * angle_q16(re, im));
			end
			nw = {16'd0, sum_w[ch]} + w;
			sum_w[ch] = (nw > WMAX) ? WMAX : nw[47:0];
		endfunction

		function void check_result(wsa_pkg::out_item_t act);
			wsa_pkg::out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, act);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (act.mean_re !== e.mean_re) begin
				$display("%0t: mean_re exp %h act %h", $time, e.mean_re, act.mean_re);
				errors++;
			end
			if (act.mean_im !== e.mean_im) begin
				$display("%0t: mean_im exp %h act %h", $time, e.mean_im, act.mean_im);
				errors++;
			end
			if (act.total_weight !== e.total_weight) begin
				$display("%0t: total_weight exp %h act %h", $time, e.total_weight,
					act.total_weight);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	wsa_pkg::in_item_t in_data;
	wsa_pkg::out_item_t out_data;
	logic [2:0] cfg_index;
	logic [wsa_pkg::CFG_DW-1:0] cfg_wdata;
	int hold_off;
	spectrum_scoreboard sb;

	weighted_spectrum_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	initial begin
		#100000000;
		$display("FAILED: results differ");
		$finish;
	end

	// receiver: own stall pattern plus one long hold-off
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_data);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(0, 3) != 0) || ($time / 20000) % 3 == 0;
	end

	task automatic write_reg(wsa_pkg::cfg_idx_t idx, logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wsa_pkg::CFG_VECTOR_MODE: sb.cfg.vector_mode = val[0];
			wsa_pkg::CFG_UV_MIN: sb.cfg.uv_min = val;
			wsa_pkg::CFG_UV_MAX: sb.cfg.uv_max = val;
			wsa_pkg::CFG_FIRST_RECORD: sb.cfg.first_record = val[19:0];
			wsa_pkg::CFG_LAST_RECORD: sb.cfg.last_record = val[19:0];
			wsa_pkg::CFG_WEIGHT_SCALE: sb.cfg.weight_scale = val[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_item(wsa_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic wsa_pkg::in_item_t rand_item(int nch, bit rd, bit tame);
		wsa_pkg::in_item_t it;
		it.kind = rd;
		it.channel = $urandom_range(0, nch - 1);
		it.record_index = $urandom_range(0, 1048575);
		it.u_coord = tame ? $signed($urandom_range(0, 4000)) - 2000 : $urandom;
		it.v_coord = tame ? $signed($urandom_range(0, 4000)) - 2000 : $urandom;
		it.sample_re = $urandom;
		it.sample_im = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			it.sample_re = $signed($urandom_range(0, 200000)) - 100000;
			it.sample_im = $signed($urandom_range(0, 200000)) - 100000;
		end
		it.sample_weight = tame ? $urandom_range(1, 8388607) : $urandom;
		return it;
	endfunction

	task automatic run_phase(int count, int nch);
		int burst;
		int gap;
		wsa_pkg::in_item_t it;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 20);
			end
			burst--;
			it = rand_item(nch, $urandom_range(0, 4) == 0, $urandom_range(0, 4) != 0);
			send_item(it);
		end
		in_valid <= 1'b0;
		drain();
	endtask

	initial begin
		wsa_pkg::in_item_t it;
		sb = new();
		sb.clear_all();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		hold_off = 0;
		cfg_we = 1'b0;
		cfg_index = wsa_pkg::CFG_VECTOR_MODE;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, both kinds, zero sample, zero-weight read
		it = '0;
		it.kind = 1'b1; send_item(it);
		it = '0; it.channel = 10'd1023; it.sample_weight = 24'sh7FFFFF;
		it.sample_re = 32'sh7FFFFFFF; it.sample_im = 32'sh80000000;
		it.record_index = 20'hFFFFF;
		it.u_coord = 32'sh80000000; it.v_coord = 32'sh7FFFFFFF;
		repeat (3) send_item(it);
		it.kind = 1'b1; send_item(it);
		it = '0; it.channel = 10'd5; it.sample_weight = 24'sh800000; send_item(it);
		it.sample_weight = 0; send_item(it);
		it.sample_weight = 1; send_item(it);
		it.kind = 1'b1; send_item(it);
		in_valid <= 1'b0;
		drain();
		write_reg(wsa_pkg::CFG_VECTOR_MODE, 0);
		it = '0; it.channel = 10'd7; it.sample_weight = 24'd65536; send_item(it);
		it.sample_re = -32'sd65536; it.sample_im = 0; send_item(it);
		it.sample_re = -32'sd65536; it.sample_im = -32'sd1; send_item(it);
		it.sample_re = 32'sh80000000; it.sample_im = 32'sh80000000; send_item(it);
		it.kind = 1'b1; send_item(it);
		in_valid <= 1'b0;
		drain();

		run_phase(300, 8);
		write_reg(wsa_pkg::CFG_VECTOR_MODE, 1);
		write_reg(wsa_pkg::CFG_UV_MIN, 500);
		write_reg(wsa_pkg::CFG_UV_MAX, 1500);
		write_reg(wsa_pkg::CFG_FIRST_RECORD, 20'h10000);
		write_reg(wsa_pkg::CFG_LAST_RECORD, 20'hC0000);
		write_reg(wsa_pkg::CFG_WEIGHT_SCALE, 24'hFFFFFF);
		fork
			hold_off = 3000;
			run_phase(300, 4);
		join
		write_reg(wsa_pkg::CFG_UV_MIN, 31'h7FFFFFFF);
		write_reg(wsa_pkg::CFG_UV_MAX, 31'h7FFFFFFF);
		write_reg(wsa_pkg::CFG_WEIGHT_SCALE, 0);
		run_phase(150, 16);
		write_reg(wsa_pkg::CFG_UV_MIN, 1500);
		write_reg(wsa_pkg::CFG_UV_MAX, 500);
		write_reg(wsa_pkg::CFG_FIRST_RECORD, 20'hFFFFF);
		write_reg(wsa_pkg::CFG_LAST_RECORD, 0);
		run_phase(100, 8);
		write_reg(wsa_pkg::CFG_VECTOR_MODE, 0);
		write_reg(wsa_pkg::CFG_UV_MIN, 0);
		write_reg(wsa_pkg::CFG_UV_MAX, 0);
		write_reg(wsa_pkg::CFG_FIRST_RECORD, 0);
		write_reg(wsa_pkg::CFG_LAST_RECORD, 20'hFFFFF);
		write_reg(wsa_pkg::CFG_WEIGHT_SCALE, 24'd32768);
		run_phase(450, 8);
		write_reg(wsa_pkg::CFG_VECTOR_MODE, 1);
		write_reg(wsa_pkg::CFG_WEIGHT_SCALE, 24'd65536);
		run_phase(450, 1024);

		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
